/* rtl/itar_pkg.sv */
// ----------------------------------------------------------------------------
// itar_pkg
// Shared types, constants and character helpers for the radix text converter.
// ----------------------------------------------------------------------------
package itar_pkg;

  // Bits of the input value that take part in a conversion.
  localparam int VALUE_BITS = 64;

  // Digit slots needed for each radix at VALUE_BITS.
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DIG_MAX_OH = (OCT_DIGITS > HEX_DIGITS) ? OCT_DIGITS : HEX_DIGITS;
  localparam int DIG_SLOTS  = (DIG_MAX_OH > DEC_DIGITS) ? DIG_MAX_OH : DEC_DIGITS;
  localparam int PAD_BITS   = DIG_SLOTS * 4;

  localparam int CNT_W = $clog2(DIG_SLOTS + 1);
  localparam int IDX_W = $clog2(DIG_SLOTS);
  localparam int BIT_W = $clog2(VALUE_BITS + 1);

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Request and radix selector codes.
  localparam logic REQ_NUMBER  = 1'b0;
  localparam logic REQ_ADDRESS = 1'b1;
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;

  // ASCII codes.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] DIGIT_TEN    = 8'd10;

  typedef enum logic [1:0] {
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DABBLE,
    BK_PRE,
    BK_PREX,
    BK_DIGITS
  } back_state_t;

  // One classified conversion as it travels from front to back.
  typedef struct packed {
    logic                  addr;
    logic                  neg;
    radix_t                radix;
    logic                  upper;
    logic [VALUE_BITS-1:0] mag;
  } itar_item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] wide;
    wide = {4'b0000, d};
    if (wide < DIGIT_TEN) begin
      digit_char = CHAR_ZERO + wide;
    end else if (upper) begin
      digit_char = CHAR_UPPER_A + wide - DIGIT_TEN;
    end else begin
      digit_char = CHAR_LOWER_A + wide - DIGIT_TEN;
    end
  endfunction

endpackage

/* rtl/itar_front.sv */
// ----------------------------------------------------------------------------
// itar_front
// Accept input beats, classify them and take the magnitude of negative values.
// ----------------------------------------------------------------------------
module itar_front import itar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [63:0] value,
  input  logic [1:0]  base_sel,
  input  logic        upper_case,
  output logic        push_valid,
  input  logic        push_ready,
  output itar_item_t  push_item
);

  logic                  held;
  itar_item_t            item;
  itar_item_t            item_next;
  logic [VALUE_BITS-1:0] v;
  logic                  is_neg;
  radix_t                radix;

  assign v = value[VALUE_BITS-1:0];

  always_comb begin
    if (req_type == REQ_ADDRESS) begin
      radix = RADIX_HEX;
    end else begin
      case (base_sel)
        BASE_OCT: radix = RADIX_OCT;
        BASE_DEC: radix = RADIX_DEC;
        default:  radix = RADIX_HEX;
      endcase
    end
  end

  always_comb begin
    is_neg          = (req_type == REQ_NUMBER) && v[VALUE_BITS-1];
    item_next.addr  = (req_type == REQ_ADDRESS);
    item_next.neg   = is_neg;
    item_next.radix = radix;
    item_next.upper = (req_type == REQ_NUMBER) && upper_case && (radix == RADIX_HEX);
    item_next.mag   = is_neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
  end

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

/* rtl/itar_queue.sv */
// ----------------------------------------------------------------------------
// itar_queue
// Short FIFO of classified conversions between front and back.
// ----------------------------------------------------------------------------
module itar_queue import itar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  itar_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output itar_item_t pop_item
);

  itar_item_t       mem [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != QC_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QC_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/itar_back.sv */
// ----------------------------------------------------------------------------
// itar_back
// Convert one queued value to digits and emit its text one character a beat.
// ----------------------------------------------------------------------------
module itar_back import itar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  itar_item_t pop_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_char
);

  back_state_t           state;
  back_state_t           state_next;
  logic [3:0]            dig [DIG_SLOTS];
  logic [3:0]            load_dig [DIG_SLOTS];
  logic [3:0]            dab_dig [DIG_SLOTS];
  logic [3:0]            adj [DIG_SLOTS];
  logic [VALUE_BITS-1:0] sr;
  logic [BIT_W-1:0]      bit_cnt;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  leading;
  logic                  addr;
  logic                  neg;
  logic                  upper;
  logic [PAD_BITS-1:0]   padded;
  logic [3:0]            top;
  logic                  slot_free;
  logic                  can_skip;
  logic                  load;
  logic                  step;
  logic                  skip;
  logic                  take;
  logic                  emit;
  logic [7:0]            emit_char;
  logic                  emit_last;
  logic                  o_valid;
  logic [7:0]            o_char;
  logic                  o_last;

  assign slot_free = !o_valid || out_ready;
  assign cnt_m1    = cnt - CNT_W'(1);
  assign top       = dig[cnt_m1[IDX_W-1:0]];
  assign can_skip  = leading && (top == 4'd0) && (cnt != CNT_W'(1));
  assign padded    = PAD_BITS'(pop_item.mag);

  // Digits straight from the bits for octal and hex; decimal starts clear.
  always_comb begin
    for (int i = 0; i < DIG_SLOTS; i++) begin
      case (pop_item.radix)
        RADIX_OCT: load_dig[i] = {1'b0, padded[3*i +: 3]};
        RADIX_HEX: load_dig[i] = padded[4*i +: 4];
        default:   load_dig[i] = 4'd0;
      endcase
    end
  end

  // One shift-and-add-3 step over the decimal digits.
  always_comb begin
    for (int i = 0; i < DIG_SLOTS; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
    for (int i = 0; i < DIG_SLOTS; i++) begin
      if (i == 0) begin
        dab_dig[i] = {adj[i][2:0], sr[VALUE_BITS-1]};
      end else if (i < DEC_DIGITS) begin
        dab_dig[i] = {adj[i][2:0], adj[i-1][3]};
      end else begin
        dab_dig[i] = 4'd0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_item.radix == RADIX_DEC) ? BK_DABBLE : BK_PRE;
        end
      end
      BK_DABBLE: begin
        if (bit_cnt == BIT_W'(1)) begin
          state_next = BK_PRE;
        end
      end
      BK_PRE: begin
        if (addr) begin
          if (slot_free) begin
            state_next = BK_PREX;
          end
        end else if (!neg || slot_free) begin
          state_next = BK_DIGITS;
        end
      end
      BK_PREX: begin
        if (slot_free) begin
          state_next = BK_DIGITS;
        end
      end
      BK_DIGITS: begin
        if (!can_skip && slot_free && cnt == CNT_W'(1)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    load      = 1'b0;
    step      = 1'b0;
    skip      = 1'b0;
    take      = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        load      = pop_valid;
      end
      BK_DABBLE: begin
        step = 1'b1;
      end
      BK_PRE: begin
        if (addr) begin
          emit      = slot_free;
          emit_char = CHAR_ZERO;
        end else if (neg) begin
          emit      = slot_free;
          emit_char = CHAR_MINUS;
        end
      end
      BK_PREX: begin
        emit      = slot_free;
        emit_char = CHAR_X;
      end
      BK_DIGITS: begin
        if (can_skip) begin
          skip = 1'b1;
        end else begin
          take      = slot_free;
          emit      = slot_free;
          emit_char = digit_char(top, upper);
          emit_last = (cnt == CNT_W'(1));
        end
      end
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_char <= emit_char;
      o_last <= emit_last;
    end
    if (load) begin
      addr    <= pop_item.addr;
      neg     <= pop_item.neg;
      upper   <= pop_item.upper;
      sr      <= pop_item.mag;
      bit_cnt <= BIT_W'(VALUE_BITS);
      leading <= 1'b1;
      case (pop_item.radix)
        RADIX_OCT: cnt <= CNT_W'(OCT_DIGITS);
        RADIX_DEC: cnt <= CNT_W'(DEC_DIGITS);
        default:   cnt <= CNT_W'(HEX_DIGITS);
      endcase
      for (int i = 0; i < DIG_SLOTS; i++) begin
        dig[i] <= load_dig[i];
      end
    end else if (step) begin
      sr      <= {sr[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - BIT_W'(1);
      for (int i = 0; i < DIG_SLOTS; i++) begin
        dig[i] <= dab_dig[i];
      end
    end else if (skip) begin
      cnt <= cnt_m1;
    end else if (take) begin
      cnt     <= cnt_m1;
      leading <= 1'b0;
    end
  end

  assign out_valid = o_valid;
  assign out_char  = o_char;
  assign last_char = o_last;

endmodule

/* rtl/integer_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Binary to ASCII text converter: octal, decimal or hex numbers, 0x addresses.
// ----------------------------------------------------------------------------
// Each input beat carries one value; the block returns its text as a run of
// output beats, one ASCII character each, most significant first, with
// last_char set on the final one. Octal and hex runs go through a load
// step, a sign step ('-' if negative, a pass-through otherwise; in address
// mode "0" and then "x") and one step per digit slot, either a leading zero
// dropped or a digit emitted. Decimal adds VALUE_BITS (64) shift-and-add-3
// steps in the back end before the first character and has 20 digit slots.
// The back end works on one value at a time; the front stage and a two-entry
// queue hold up to three further values, so input beats keep being taken
// while a run is being emitted. Output ready may drop at any time: the
// current character is held in the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix import itar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [63:0] value,
  input  logic [1:0]  base_sel,
  input  logic        upper_case,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last_char
);

  // Classified values from front to queue, and from queue to back.
  logic       push_valid;
  logic       push_ready;
  itar_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  itar_item_t pop_item;

  // Front: accept the beat, pick the radix, take the magnitude.
  itar_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .value      (value),
    .base_sel   (base_sel),
    .upper_case (upper_case),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue: decouple acceptance from the long character runs.
  itar_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: form the digits, drop leading zeros, emit characters.
  itar_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

/* tb/sv/integer_to_ascii_radix_tb.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb
// Self-checking bench for the radix text converter.
// ----------------------------------------------------------------------------
// A queue of conversion requests feeds a driver that presents one request per
// input beat, with random idle gaps. Every accepted request is turned into
// its expected text by a predictor written here. A monitor compares each
// output beat, character and last flag, against the oldest expected
// character. Output ready stalls at random. A directed set covers zero,
// extreme and most negative values in every radix, both digit cases, the
// spare radix code and address mode. A random set with mixed magnitudes
// follows. Twice the driver holds off until all expected text has arrived.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;
  import itar_pkg::*;

  // Hex codes not named in the package: code two, and the spare code three,
  // which the block also treats as hex.
  localparam logic [1:0] BASE_HEX       = 2'd2;
  localparam logic [1:0] BASE_SPARE_HEX = 2'd3;

  localparam int TAIL_CYCLES = 200;

  // One pending request; hold_off marks a pause until all text is back.
  typedef struct {
    logic        req;
    logic [63:0] val;
    logic [1:0]  base;
    logic        upper;
    bit          hold_off;
  } conv_req_t;

  // One expected output beat.
  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } text_beat_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        req_type   = REQ_NUMBER;
  logic [63:0] value      = 64'd0;
  logic [1:0]  base_sel   = BASE_OCT;
  logic        upper_case = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [7:0]  out_char;
  logic        last_char;

  conv_req_t   pending[$];
  text_beat_t  text_due[$];
  conv_req_t   next_req;
  conv_req_t   seen_req;
  text_beat_t  due_beat;

  logic        in_fire      = 1'b0;
  int unsigned in_idle_left = 0;
  int unsigned out_stall    = 0;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;
  int unsigned req_total    = 0;
  int unsigned req_taken    = 0;
  int unsigned errors       = 0;

  integer_to_ascii_radix u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .value      (value),
    .base_sel   (base_sel),
    .upper_case (upper_case),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last_char  (last_char)
  );

  always #2 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Work out the text of one request and queue its characters, most
  // significant first, with the last flag on the final one.
  task automatic predict_text(input conv_req_t r);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [7:0]  rev[0:23];
    logic [7:0]  d;
    logic        up;
    logic        neg;
    int          n;
    text_beat_t  b;
    mask = ~64'd0 >> (64 - VALUE_BITS);
    v    = r.val & mask;
    n    = 0;
    if (r.req == REQ_ADDRESS) begin
      radix = 64'd16;
      up    = 1'b0;
      neg   = 1'b0;
      mag   = v;
    end else begin
      radix = (r.base == BASE_OCT) ? 64'd8 : (r.base == BASE_DEC) ? 64'd10 : 64'd16;
      up    = r.upper && (radix == 64'd16);
      neg   = v[VALUE_BITS-1];
      // Two's complement magnitude; the most negative value keeps its top bit.
      mag   = neg ? ((~v + 64'd1) & mask) : v;
    end
    // Collect digits least significant first; zero still yields one digit.
    do begin
      d = 8'(mag % radix);
      if (d < DIGIT_TEN) begin
        rev[n] = CHAR_ZERO + d;
      end else begin
        rev[n] = (up ? CHAR_UPPER_A : CHAR_LOWER_A) + d - DIGIT_TEN;
      end
      n++;
      mag = mag / radix;
    end while (mag != 64'd0);
    if (r.req == REQ_ADDRESS) begin
      rev[n] = CHAR_X;
      n++;
      rev[n] = CHAR_ZERO;
      n++;
    end else if (neg) begin
      rev[n] = CHAR_MINUS;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      b.ch      = rev[k];
      b.is_last = (k == 0);
      text_due.push_back(b);
    end
  endtask

  task automatic add_req(input logic req, input logic [63:0] val,
                         input logic [1:0] base, input logic upper);
    conv_req_t r;
    r.req      = req;
    r.val      = val;
    r.base     = base;
    r.upper    = upper;
    r.hold_off = 1'b0;
    pending.push_back(r);
    req_total++;
  endtask

  task automatic add_hold_off();
    conv_req_t r;
    r.req      = REQ_NUMBER;
    r.val      = 64'd0;
    r.base     = BASE_OCT;
    r.upper    = 1'b0;
    r.hold_off = 1'b1;
    pending.push_back(r);
  endtask

  // Input driver: change at the falling edge. Hold the beat while it waits
  // for ready; once it has gone, idle for the chosen gap, then present the
  // next request. A hold-off entry stalls the sender until all text is back.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_idle_left != 0) begin
        in_valid     <= 1'b0;
        in_idle_left <= in_idle_left - 1;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending[0].hold_off) begin
        in_valid <= 1'b0;
        if (text_due.size() == 0) begin
          pending.delete(0);
        end
      end else begin
        next_req = pending[0];
        pending.delete(0);
        req_type     <= next_req.req;
        value        <= next_req.val;
        base_sel     <= next_req.base;
        upper_case   <= next_req.upper;
        in_valid     <= 1'b1;
        in_idle_left <= in_calm ? 0 : pick_gap();
      end
    end
    // Flip now and then into a stretch with no idling, and back.
    if ($urandom_range(0, 149) == 0) begin
      in_calm <= !in_calm;
    end
  end

  // Output ready: stall for random stretches, except in calm stretches.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_stall <= pick_gap();
      end
    end
    if ($urandom_range(0, 149) == 0) begin
      out_calm <= !out_calm;
    end
  end

  // Monitor: sample at the rising edge. Check the output beat first, then
  // predict the text of any request taken on the same edge.
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (text_due.size() == 0) begin
          report_mismatch($sformatf("char %02h with nothing expected", out_char));
        end else begin
          due_beat = text_due.pop_front();
          if (out_char !== due_beat.ch) begin
            report_mismatch($sformatf("out_char %02h, expected %02h",
                                      out_char, due_beat.ch));
          end
          if (last_char !== due_beat.is_last) begin
            report_mismatch($sformatf("last_char %0b, expected %0b",
                                      last_char, due_beat.is_last));
          end
        end
      end
      if (in_valid && in_ready) begin
        seen_req.req      = req_type;
        seen_req.val      = value;
        seen_req.base     = base_sel;
        seen_req.upper    = upper_case;
        seen_req.hold_off = 1'b0;
        predict_text(seen_req);
        req_taken++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [63:0] raw;
    int unsigned width;
    logic        req;
    // Directed: zero, extremes and most negative in every radix.
    add_req(REQ_NUMBER, 64'd0, BASE_OCT, 1'b0);
    add_req(REQ_NUMBER, 64'd0, BASE_DEC, 1'b0);
    add_req(REQ_NUMBER, 64'd0, BASE_HEX, 1'b1);
    add_req(REQ_ADDRESS, 64'd0, BASE_OCT, 1'b0);
    add_req(REQ_NUMBER, 64'h7FFF_FFFF_FFFF_FFFF, BASE_OCT, 1'b0);
    add_req(REQ_NUMBER, 64'h7FFF_FFFF_FFFF_FFFF, BASE_DEC, 1'b0);
    add_req(REQ_NUMBER, 64'h7FFF_FFFF_FFFF_FFFF, BASE_HEX, 1'b1);
    add_req(REQ_NUMBER, 64'h8000_0000_0000_0000, BASE_OCT, 1'b0);
    add_req(REQ_NUMBER, 64'h8000_0000_0000_0000, BASE_DEC, 1'b1);
    add_req(REQ_NUMBER, 64'h8000_0000_0000_0000, BASE_HEX, 1'b0);
    add_req(REQ_NUMBER, ~64'd0, BASE_OCT, 1'b0);
    add_req(REQ_NUMBER, ~64'd0, BASE_DEC, 1'b0);
    add_req(REQ_NUMBER, ~64'd0, BASE_HEX, 1'b0);
    // Digit case, and the spare radix code taken as hex.
    add_req(REQ_NUMBER, 64'h0ABC_DEF0_1234_5678, BASE_HEX, 1'b0);
    add_req(REQ_NUMBER, 64'h0ABC_DEF0_1234_5678, BASE_HEX, 1'b1);
    add_req(REQ_NUMBER, 64'h0ABC_DEF0_1234_5678, BASE_SPARE_HEX, 1'b1);
    add_req(REQ_NUMBER, 64'hFFFF_FFFF_FFFF_FF06, BASE_SPARE_HEX, 1'b0);
    // Address mode ignores case and radix.
    add_req(REQ_ADDRESS, ~64'd0, BASE_DEC, 1'b1);
    add_req(REQ_ADDRESS, 64'h8000_0000_0000_0000, BASE_SPARE_HEX, 1'b0);
    add_req(REQ_ADDRESS, 64'h0000_7FFE_DCBA_9876, BASE_OCT, 1'b1);
    add_req(REQ_NUMBER, 64'd9, BASE_DEC, 1'b0);
    add_req(REQ_NUMBER, 64'd10, BASE_DEC, 1'b0);
    add_req(REQ_NUMBER, 64'd8, BASE_OCT, 1'b0);
    add_hold_off();

    // Random: magnitudes of every width, sign flipped half the time.
    for (int i = 0; i < 157; i++) begin
      raw   = {$urandom, $urandom};
      width = $urandom_range(1, 64);
      raw   = raw & (~64'd0 >> (64 - width));
      if ($urandom_range(0, 1) == 1) begin
        raw = ~raw + 64'd1;
      end
      req = ($urandom_range(0, 9) < 3) ? REQ_ADDRESS : REQ_NUMBER;
      add_req(req, raw, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if (i == 90) begin
        add_hold_off();
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: wait for every request to go in and all text to come back,
    // then give stray beats time to show.
    while (req_taken != req_total || text_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(4 * 1_500_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* integer_to_ascii_radix.f */
rtl/itar_pkg.sv
rtl/itar_front.sv
rtl/itar_queue.sv
rtl/itar_back.sv
rtl/integer_to_ascii_radix.sv
tb/sv/integer_to_ascii_radix_tb.sv
